/* hdl/mlse_pkg.sv */
// mlse_pkg: shared types and constants of the label stack engine
// operation and status codes, stack entry and result records, state commands
// no dependencies
package mlse_pkg;

  // operation codes carried in the input tuser
  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_LOAD  = 3'd1,
    OP_CHECK = 3'd2,
    OP_PUSH  = 3'd3,
    OP_SWAP  = 3'd4,
    OP_POP   = 3'd5,
    OP_READ  = 3'd6
  } op_t;

  // result status codes carried in the output tuser
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TTL_EXPIRED = 3'd1,
    ST_NULL_POPPED = 3'd2,
    ST_RESERVED    = 3'd3,
    ST_OVERFLOW    = 3'd4,
    ST_EMPTY       = 3'd5,
    ST_IGNORED     = 3'd6
  } status_t;

  // configuration register indexes
  localparam logic [1:0] CFG_TTL_MODE    = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_TTL = 2'd1;
  localparam logic [1:0] CFG_WRITE_TC    = 2'd2;

  // most result beats a read out gives
  localparam int RD_BEATS_MAX = 4;

  // reserved label range reported on check
  localparam logic [19:0] LABEL_EXPLICIT_NULL = 20'd0;
  localparam logic [19:0] LABEL_RSV_LO        = 20'd4;
  localparam logic [19:0] LABEL_RSV_HI        = 20'd15;

  localparam logic [7:0] TTL_ONE = 8'd1;

  typedef struct packed {
    logic [19:0] label;
    logic [2:0]  tc;
    logic [7:0]  ttl;
  } entry_t;

  // one result beat
  typedef struct packed {
    status_t     status;
    entry_t      ent;
    logic        bottom;
    logic [7:0]  ip_ttl;
    logic [5:0]  dscp;
    logic        labeled;
  } res_t;

  // update of stack and packet state for one accepted item
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       swap;
    logic       clear;
    entry_t     wr;
    logic       ip_ttl_we;
    logic [7:0] ip_ttl;
    logic       dscp_we;
    logic [5:0] dscp;
    logic       set_exp;
    logic       clr_exp;
  } state_cmd_t;

endpackage

/* hdl/mlse_state.sv */
// mlse_state: label stack as a shift register (top at entry 0), fill count,
// packet ip ttl / dscp and the expiry flag
// depends on mlse_pkg
module mlse_state #(
  parameter int STACK_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  mlse_pkg::state_cmd_t               cmd,
  output mlse_pkg::entry_t                   ent [STACK_DEPTH],
  output logic [$clog2(STACK_DEPTH+1)-1:0]   cnt,
  output logic [7:0]                         ip_ttl,
  output logic [5:0]                         ip_dscp,
  output logic                               expired
);
  import mlse_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  // stack entries, no reset: only entries below the count are read
  always_ff @(posedge clk) begin
    if (en) begin
      if (cmd.push) begin
        for (int i = STACK_DEPTH - 1; i > 0; i--) begin
          ent[i] <= ent[i-1];
        end
        ent[0] <= cmd.wr;
      end else if (cmd.pop) begin
        for (int i = 0; i < STACK_DEPTH - 1; i++) begin
          ent[i] <= ent[i+1];
        end
      end else if (cmd.swap) begin
        ent[0] <= cmd.wr;
      end
    end
  end

  // count, ip fields and expiry
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      ip_ttl  <= '0;
      ip_dscp <= '0;
      expired <= 1'b0;
    end else if (en) begin
      if (cmd.clear) begin
        cnt <= '0;
      end else if (cmd.push) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.pop) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.ip_ttl_we) begin
        ip_ttl <= cmd.ip_ttl;
      end
      if (cmd.dscp_we) begin
        ip_dscp <= cmd.dscp;
      end
      if (cmd.set_exp) begin
        expired <= 1'b1;
      end else if (cmd.clr_exp) begin
        expired <= 1'b0;
      end
    end
  end

endmodule

/* hdl/mlse_decode.sv */
// mlse_decode: applies one operation to the current top entry and packet
// state, giving the state update and the first result beat
// depends on mlse_pkg
module mlse_decode #(
  parameter int STACK_DEPTH = 4
) (
  input  mlse_pkg::op_t                      op,
  input  logic [19:0]                        label,
  input  logic [2:0]                         traffic_class,
  input  logic [7:0]                         entry_ttl,
  input  logic [7:0]                         start_ip_ttl,
  input  logic [5:0]                         start_dscp,
  input  logic                               payload_ipv4,
  input  logic                               ttl_mode,
  input  logic [7:0]                         default_ttl,
  input  logic                               write_tc_on_pop,
  input  mlse_pkg::entry_t                   top,
  input  logic [$clog2(STACK_DEPTH+1)-1:0]   cnt,
  input  logic [7:0]                         ip_ttl,
  input  logic [5:0]                         ip_dscp,
  input  logic                               expired,
  output mlse_pkg::state_cmd_t               cmd,
  output mlse_pkg::res_t                     res,
  output logic                               is_read
);
  import mlse_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic   empty;
  logic   full;
  logic   single;
  logic   pop_ipv4;
  logic   reserved;
  entry_t new_ent;

  assign empty    = (cnt == '0);
  assign full     = (cnt == CW'(STACK_DEPTH));
  assign single   = (cnt == CW'(1));
  assign reserved = (top.label >= LABEL_RSV_LO) && (top.label <= LABEL_RSV_HI);
  // explicit null on check is always popped as over ipv4
  assign pop_ipv4 = (op == OP_CHECK) ? 1'b1 : payload_ipv4;

  // entry written by load or push
  always_comb begin
    new_ent.label = label;
    if (op == OP_LOAD) begin
      new_ent.tc  = traffic_class;
      new_ent.ttl = entry_ttl;
    end else if (!empty) begin
      new_ent.tc  = top.tc;
      new_ent.ttl = top.ttl;
    end else begin
      new_ent.tc  = ip_dscp[5:3];
      new_ent.ttl = ttl_mode ? default_ttl : ip_ttl;
    end
  end

  // operation decode
  always_comb begin
    cmd         = '0;
    res         = '0;
    res.status  = ST_OK;
    res.ip_ttl  = ip_ttl;
    res.dscp    = ip_dscp;
    res.labeled = !empty;
    is_read     = 1'b0;

    if (op == OP_START) begin
      cmd.clear     = 1'b1;
      cmd.clr_exp   = 1'b1;
      cmd.ip_ttl_we = 1'b1;
      cmd.ip_ttl    = start_ip_ttl;
      cmd.dscp_we   = 1'b1;
      cmd.dscp      = start_dscp;
      res.ip_ttl    = start_ip_ttl;
      res.dscp      = start_dscp;
      res.labeled   = 1'b0;
    end else if (expired) begin
      res.status = ST_IGNORED;
    end else begin
      case (op)
        OP_LOAD, OP_PUSH: begin
          if (full) begin
            res.status = ST_OVERFLOW;
          end else begin
            cmd.push    = 1'b1;
            cmd.wr      = new_ent;
            res.ent     = new_ent;
            res.bottom  = empty;
            res.labeled = 1'b1;
          end
        end
        OP_CHECK, OP_POP: begin
          if (empty) begin
            res.status = ST_EMPTY;
          end else if (op == OP_CHECK && top.label != LABEL_EXPLICIT_NULL) begin
            res.status = reserved ? ST_RESERVED : ST_OK;
            res.ent    = top;
            res.bottom = single;
          end else begin
            // pop of the top entry, bottom pop may restore ip fields
            if (op == OP_CHECK) begin
              res.status = ST_NULL_POPPED;
            end
            cmd.pop     = 1'b1;
            res.ent     = top;
            res.bottom  = single;
            res.labeled = !single;
            if (single && pop_ipv4 && !ttl_mode) begin
              cmd.ip_ttl_we = 1'b1;
              cmd.ip_ttl    = top.ttl;
              res.ip_ttl    = top.ttl;
              if (write_tc_on_pop) begin
                cmd.dscp_we = 1'b1;
                cmd.dscp    = {top.tc, 3'b000};
                res.dscp    = {top.tc, 3'b000};
              end
            end
          end
        end
        OP_SWAP: begin
          if (empty) begin
            res.status = ST_EMPTY;
          end else if (top.ttl <= TTL_ONE) begin
            // ttl expiry drops the stack and zeroes the ip ttl
            res.status    = ST_TTL_EXPIRED;
            cmd.clear     = 1'b1;
            cmd.set_exp   = 1'b1;
            cmd.ip_ttl_we = 1'b1;
            cmd.ip_ttl    = '0;
            res.ent       = top;
            res.bottom    = single;
            res.ip_ttl    = '0;
            res.labeled   = 1'b0;
          end else begin
            cmd.swap      = 1'b1;
            cmd.wr.label  = label;
            cmd.wr.tc     = top.tc;
            cmd.wr.ttl    = top.ttl - TTL_ONE;
            res.ent.label = label;
            res.ent.tc    = top.tc;
            res.ent.ttl   = top.ttl - TTL_ONE;
            res.bottom    = single;
          end
        end
        OP_READ: begin
          is_read = 1'b1;
          if (!empty) begin
            res.ent    = top;
            res.bottom = single;
          end
        end
        default: begin
          res.status = ST_IGNORED;
        end
      endcase
    end
  end

endmodule

/* hdl/mlse_out.sv */
// mlse_out: output register of the result channel; steps a read out
// through the upper stack entries one beat at a time
// depends on mlse_pkg
module mlse_out #(
  parameter int STACK_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic                               is_read,
  input  mlse_pkg::res_t                     res_in,
  input  mlse_pkg::entry_t                   ent [STACK_DEPTH],
  input  logic [$clog2(STACK_DEPTH+1)-1:0]   cnt,
  input  logic [7:0]                         ip_ttl,
  input  logic [5:0]                         ip_dscp,
  input  logic                               ready,
  output logic                               valid,
  output mlse_pkg::res_t                     res,
  output logic                               last
);
  import mlse_pkg::*;

  localparam int CW     = $clog2(STACK_DEPTH + 1);
  localparam int RD_MAX = (STACK_DEPTH < RD_BEATS_MAX) ? STACK_DEPTH : RD_BEATS_MAX;

  logic [CW-1:0] beat;
  logic [CW-1:0] rem;
  logic [CW-1:0] rd_n;
  entry_t        sel;
  res_t          rd_res;

  // number of entries a read out reports
  assign rd_n = (cnt > CW'(RD_MAX)) ? CW'(RD_MAX) : cnt;

  // entry of the next read out beat
  always_comb begin
    sel = '0;
    for (int i = 0; i < RD_MAX; i++) begin
      if (beat == CW'(i)) begin
        sel = ent[i];
      end
    end
    rd_res         = '0;
    rd_res.status  = ST_OK;
    rd_res.ent     = sel;
    rd_res.bottom  = (beat == cnt - CW'(1));
    rd_res.ip_ttl  = ip_ttl;
    rd_res.dscp    = ip_dscp;
    rd_res.labeled = 1'b1;
  end

  // result register and read out sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      last  <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
      res   <= res_in;
      beat  <= CW'(1);
      if (is_read) begin
        last <= (rd_n <= CW'(1));
        rem  <= (rd_n == '0) ? '0 : rd_n - CW'(1);
      end else begin
        last <= 1'b1;
        rem  <= '0;
      end
    end else if (valid && ready) begin
      if (last) begin
        valid <= 1'b0;
      end else begin
        res  <= rd_res;
        beat <= beat + CW'(1);
        rem  <= rem - CW'(1);
        last <= (rem == CW'(1));
      end
    end
  end

endmodule

/* hdl/mpls_label_stack_engine.sv */
// mpls_label_stack_engine: top level of the per-packet label stack engine
// config registers, input handshake, state, decode and output stage
// depends on mlse_pkg, mlse_state, mlse_decode, mlse_out
//
// Usage
//   s_* carries one operation per beat: tuser is the operation code, tdata
//   the label, entry and packet fields. m_* carries result beats: tuser is
//   the status, tdata the reported entry and packet fields, tlast marks the
//   final beat of an operation. cfg_we / cfg_index / cfg_data write the ttl
//   mode, default ttl and tc write-back registers; write them while idle.
//   An accepted operation updates the stack and loads its first result beat
//   into the output register at the same edge.
//   Throughput is one operation per cycle while results drain; a read out gives
//   one beat per held entry (at most four, one if empty) and holds s_tready low
//   until its last beat is taken, as these beats are read from the live stack.
//   s_tready = output register empty, or its final beat leaving this cycle;
//   a stalled m_tready therefore holds the input side after one beat.
//   Reset clears the stack count, the ip fields, the expiry flag and the output
//   valid and loads the configuration defaults; no clearing pass is needed.
module mpls_label_stack_engine #(
  parameter int STACK_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // operation beats
  input  logic        s_tvalid,
  output logic        s_tready,
  // label[19:0], traffic_class[22:20], entry_ttl[30:23], start_ip_ttl[38:31],
  // start_dscp[44:39], payload_ipv4[45], zero[47:46]
  input  logic [47:0] s_tdata,
  // operation[2:0]
  input  logic [2:0]  s_tuser,
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_label[19:0], out_tc[22:20], out_ttl[30:23], out_bottom[31],
  // out_ip_ttl[39:32], out_dscp[45:40], labeled[46], zero[47]
  output logic [47:0] m_tdata,
  // status[2:0]
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);
  import mlse_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic          ttl_mode;
  logic [7:0]    default_ttl;
  logic          write_tc_on_pop;
  logic          accept;
  entry_t        ent [STACK_DEPTH];
  logic [CW-1:0] cnt;
  logic [7:0]    ip_ttl;
  logic [5:0]    ip_dscp;
  logic          expired;
  state_cmd_t    cmd;
  res_t          dec_res;
  logic          is_read;
  res_t          out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ttl_mode        <= 1'b0;
      default_ttl     <= 8'd255;
      write_tc_on_pop <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TTL_MODE:    ttl_mode        <= cfg_data[0];
        CFG_DEFAULT_TTL: default_ttl     <= cfg_data;
        CFG_WRITE_TC:    write_tc_on_pop <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign s_tready = !m_tvalid || (m_tready && m_tlast);
  assign accept   = s_tvalid && s_tready;

  mlse_state #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .en      (accept),
    .cmd     (cmd),
    .ent     (ent),
    .cnt     (cnt),
    .ip_ttl  (ip_ttl),
    .ip_dscp (ip_dscp),
    .expired (expired)
  );

  mlse_decode #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_decode (
    .op              (op_t'(s_tuser)),
    .label           (s_tdata[19:0]),
    .traffic_class   (s_tdata[22:20]),
    .entry_ttl       (s_tdata[30:23]),
    .start_ip_ttl    (s_tdata[38:31]),
    .start_dscp      (s_tdata[44:39]),
    .payload_ipv4    (s_tdata[45]),
    .ttl_mode        (ttl_mode),
    .default_ttl     (default_ttl),
    .write_tc_on_pop (write_tc_on_pop),
    .top             (ent[0]),
    .cnt             (cnt),
    .ip_ttl          (ip_ttl),
    .ip_dscp         (ip_dscp),
    .expired         (expired),
    .cmd             (cmd),
    .res             (dec_res),
    .is_read         (is_read)
  );

  mlse_out #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .is_read (is_read),
    .res_in  (dec_res),
    .ent     (ent),
    .cnt     (cnt),
    .ip_ttl  (ip_ttl),
    .ip_dscp (ip_dscp),
    .ready   (m_tready),
    .valid   (m_tvalid),
    .res     (out_res),
    .last    (m_tlast)
  );

  // result beat packing
  assign m_tuser = out_res.status;
  assign m_tdata = {1'b0, out_res.labeled, out_res.dscp, out_res.ip_ttl, out_res.bottom,
                    out_res.ent.ttl, out_res.ent.tc, out_res.ent.label};

endmodule

/* hdl/mlse_checker.sv */
// mlse_checker: port-level checks of the label stack engine, bound to the top
// depends on mlse_pkg and the mpls_label_stack_engine port list
module mlse_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  import mlse_pkg::*;

  // no result beat straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat present after reset");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result beat changed");

  // error results report no entry
  a_err_no_entry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_OVERFLOW || m_tuser == ST_EMPTY || m_tuser == ST_IGNORED)
      |-> m_tdata[31:0] == 32'd0)
    else $error("error result carries an entry");

  // only a read out gives more than one beat
  a_readout_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == ST_OK && m_tdata[46])
    else $error("non-final beat is not a read out beat");

  // input held off while a read out is still draining
  a_readout_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken during read out");

endmodule

bind mpls_label_stack_engine mlse_checker u_mlse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

/* verif/tb_mpls_label_stack_engine.sv */
// tb_mpls_label_stack_engine: self-checking bench for the label stack engine
// directed and random operation beats through a clocked driver, results checked by a monitor
// depends on mlse_pkg and mpls_label_stack_engine
module tb_mpls_label_stack_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import mlse_pkg::*;

  localparam int          DEPTH        = 4;
  localparam int          STALL_LIMIT  = 2000;
  localparam logic [2:0]  OP_UNDEFINED = 3'd7;

  // one operation beat as the sender sees it
  typedef struct {
    logic [2:0]  op;
    logic [19:0] label;
    logic [2:0]  tc;
    logic [7:0]  ettl;
    logic [7:0]  sttl;
    logic [5:0]  sdscp;
    logic        ipv4;
  } stack_op_t;

  // one predicted result beat
  typedef struct {
    status_t     status;
    logic [19:0] label;
    logic [2:0]  tc;
    logic [7:0]  ttl;
    logic        bottom;
    logic [7:0]  ip_ttl;
    logic [5:0]  dscp;
    logic        labeled;
    logic        last;
  } label_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  mpls_label_stack_engine #(.STACK_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  // predicted copy of the engine state and its registers
  logic [19:0] mdl_labels [DEPTH];
  logic [2:0]  mdl_tcs [DEPTH];
  logic [7:0]  mdl_ttls [DEPTH];
  int          mdl_depth = 0;
  logic [7:0]  mdl_ip_ttl = '0;
  logic [5:0]  mdl_dscp = '0;
  logic        mdl_expired = 1'b0;
  logic        pipe_mode = 1'b0;
  logic [7:0]  dflt_ttl = 8'd255;
  logic        tc_to_dscp = 1'b0;

  stack_op_t     pending_ops[$];
  label_result_t predicted_results[$];
  stack_op_t     cur_op;

  int errors = 0;
  int ops_done = 0;
  int useful_ops = 0;
  int beats_seen = 0;
  int settings_used = 1;
  int status_seen [8];
  int sender_idle_pct = 37;
  int sink_idle_pct = 49;
  int stall_cycles = 0;

  // queue a result beat reporting stack entry idx, or no entry when idx < 0
  function automatic void push_result(status_t st, int idx, logic last);
    label_result_t r;
    r.status  = st;
    r.label   = '0;
    r.tc      = '0;
    r.ttl     = '0;
    r.bottom  = 1'b0;
    if (idx >= 0) begin
      r.label  = mdl_labels[idx];
      r.tc     = mdl_tcs[idx];
      r.ttl    = mdl_ttls[idx];
      r.bottom = (idx == 0);
    end
    r.ip_ttl  = mdl_ip_ttl;
    r.dscp    = mdl_dscp;
    r.labeled = (mdl_depth > 0);
    r.last    = last;
    predicted_results.push_back(r);
  endfunction

  // drop the top entry; the bottom one over ipv4 in uniform mode copies back
  function automatic int pop_entry(logic over_ipv4);
    int idx;
    idx = mdl_depth - 1;
    mdl_depth--;
    if (idx == 0 && over_ipv4 && !pipe_mode) begin
      mdl_ip_ttl = mdl_ttls[0];
      if (tc_to_dscp)
        mdl_dscp = {mdl_tcs[0], 3'b000};
    end
    return idx;
  endfunction

  // apply one accepted operation to the predicted state, queue its results
  task automatic apply_label_op(input stack_op_t it, output status_t first_st);
    status_t    st;
    int         idx;
    int         top;
    int         n;
    logic [7:0] nt;
    logic [2:0] nc;
    st  = ST_OK;
    idx = -1;
    if (it.op == OP_START) begin
      mdl_depth   = 0;
      mdl_ip_ttl  = it.sttl;
      mdl_dscp    = it.sdscp;
      mdl_expired = 1'b0;
    end else if (mdl_expired || it.op == OP_UNDEFINED) begin
      st = ST_IGNORED;
    end else if (it.op == OP_LOAD || it.op == OP_PUSH) begin
      if (mdl_depth >= DEPTH) begin
        st = ST_OVERFLOW;
      end else begin
        if (it.op == OP_LOAD) begin
          nt = it.ettl;
          nc = it.tc;
        end else if (mdl_depth > 0) begin
          nt = mdl_ttls[mdl_depth - 1];
          nc = mdl_tcs[mdl_depth - 1];
        end else begin
          nt = pipe_mode ? dflt_ttl : mdl_ip_ttl;
          nc = mdl_dscp[5:3];
        end
        idx = mdl_depth;
        mdl_labels[idx] = it.label;
        mdl_ttls[idx]   = nt;
        mdl_tcs[idx]    = nc;
        mdl_depth++;
      end
    end else if (it.op == OP_CHECK || it.op == OP_SWAP || it.op == OP_POP) begin
      if (mdl_depth == 0) begin
        st = ST_EMPTY;
      end else begin
        top = mdl_depth - 1;
        if (it.op == OP_CHECK) begin
          if (mdl_labels[top] == LABEL_EXPLICIT_NULL) begin
            idx = pop_entry(1'b1);
            st  = ST_NULL_POPPED;
          end else begin
            idx = top;
            if (mdl_labels[top] >= LABEL_RSV_LO && mdl_labels[top] <= LABEL_RSV_HI)
              st = ST_RESERVED;
          end
        end else if (it.op == OP_SWAP) begin
          idx = top;
          if (mdl_ttls[top] <= TTL_ONE) begin
            mdl_depth   = 0;
            mdl_ip_ttl  = '0;
            mdl_expired = 1'b1;
            st          = ST_TTL_EXPIRED;
          end else begin
            mdl_labels[top] = it.label;
            mdl_ttls[top]   = mdl_ttls[top] - 8'd1;
          end
        end else begin
          idx = pop_entry(it.ipv4);
        end
      end
    end else if (mdl_depth > 0) begin
      // read out, top entry first
      n = (mdl_depth > RD_BEATS_MAX) ? RD_BEATS_MAX : mdl_depth;
      for (int k = 0; k < n; k++)
        push_result(ST_OK, mdl_depth - 1 - k, k == n - 1);
      first_st = ST_OK;
      return;
    end
    push_result(st, idx, 1'b1);
    first_st = st;
  endtask

  // driver: hands pending operations to the engine, predicts on acceptance
  always @(posedge clk) begin
    logic    next_valid;
    status_t st;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        apply_label_op(cur_op, st);
        ops_done++;
        if (st != ST_IGNORED)
          useful_ops++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_ops.size() > 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        cur_op = pending_ops.pop_front();
        s_tdata <= {2'b00, cur_op.ipv4, cur_op.sdscp, cur_op.sttl, cur_op.ettl,
                    cur_op.tc, cur_op.label};
        s_tuser <= cur_op.op;
        next_valid = 1'b1;
      end
      s_tvalid <= next_valid;
    end
  end

  function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // monitor: random back-pressure, each result beat against the oldest prediction
  always @(posedge clk) begin
    label_result_t r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        beats_seen++;
        status_seen[m_tuser]++;
        if (predicted_results.size() == 0) begin
          $display("%0t: result beat with none expected, actual status %0d tdata %h",
                   $time, m_tuser, m_tdata);
          errors++;
        end else begin
          r = predicted_results.pop_front();
          check_field("status", 20'(r.status), 20'(m_tuser));
          check_field("out_label", r.label, m_tdata[19:0]);
          check_field("out_tc", 20'(r.tc), 20'(m_tdata[22:20]));
          check_field("out_ttl", 20'(r.ttl), 20'(m_tdata[30:23]));
          check_field("out_bottom", 20'(r.bottom), 20'(m_tdata[31]));
          check_field("out_ip_ttl", 20'(r.ip_ttl), 20'(m_tdata[39:32]));
          check_field("out_dscp", 20'(r.dscp), 20'(m_tdata[45:40]));
          check_field("labeled", 20'(r.labeled), 20'(m_tdata[46]));
          check_field("last", 20'(r.last), 20'(m_tlast));
        end
      end
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("[mpls_label_stack_engine] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic stack_op_t make_op(logic [2:0] op, logic [19:0] label, logic [2:0] tc,
                                        logic [7:0] ettl, logic [7:0] sttl,
                                        logic [5:0] sdscp, logic ipv4);
    stack_op_t it;
    it.op    = op;
    it.label = label;
    it.tc    = tc;
    it.ettl  = ettl;
    it.sttl  = sttl;
    it.sdscp = sdscp;
    it.ipv4  = ipv4;
    return it;
  endfunction

  // every field random apart from the operation
  function automatic stack_op_t rand_op(logic [2:0] op);
    return make_op(op, 20'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                   6'($urandom), 1'($urandom));
  endfunction

  // labels leaning on explicit null, the other specials and the reserved range
  function automatic logic [19:0] rand_label();
    case ($urandom_range(9))
      0:       return LABEL_EXPLICIT_NULL;
      1:       return 20'($urandom_range(3, 1));
      2, 3:    return 20'($urandom_range(LABEL_RSV_HI, LABEL_RSV_LO));
      4:       return 20'd16;
      5:       return 20'hFFFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  // ttls leaning low so that swaps run into expiry
  function automatic logic [7:0] rand_ttl();
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'($urandom_range(3));
      4:          return 8'd255;
      default:    return 8'($urandom);
    endcase
  endfunction

  // one packet: start, received entries bottom first, then label operations, or a noise burst
  task automatic gen_packet();
    stack_op_t  it;
    int         n;
    logic [2:0] op;
    if ($urandom_range(9) == 0) begin
      // noise: any operation in any order
      n = $urandom_range(6, 1);
      for (int k = 0; k < n; k++) begin
        it = rand_op(3'($urandom));
        it.label = rand_label();
        pending_ops.push_back(it);
      end
      return;
    end
    it = rand_op(OP_START);
    it.sttl = rand_ttl();
    pending_ops.push_back(it);
    n = ($urandom_range(9) == 0) ? DEPTH + 1 : $urandom_range(DEPTH);
    for (int k = 0; k < n; k++) begin
      it = rand_op(OP_LOAD);
      it.label = rand_label();
      it.ettl  = rand_ttl();
      pending_ops.push_back(it);
    end
    if ($urandom_range(1))
      pending_ops.push_back(rand_op(OP_CHECK));
    n = $urandom_range(8, 2);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0, 1, 2, 3:     op = OP_PUSH;
        4, 5, 6, 7:     op = OP_SWAP;
        8, 9, 10, 11:   op = OP_POP;
        12, 13, 14:     op = OP_CHECK;
        15, 16, 17:     op = OP_READ;
        18:             op = OP_LOAD;
        default:        op = OP_UNDEFINED;
      endcase
      it = rand_op(op);
      it.label = rand_label();
      it.ettl  = rand_ttl();
      pending_ops.push_back(it);
    end
  endtask

  // hold off until every queued operation is taken and every result is back
  task automatic wait_idle();
    while (pending_ops.size() != 0 || s_tvalid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_TTL_MODE:    pipe_mode  = val[0];
      CFG_DEFAULT_TTL: dflt_ttl   = val;
      CFG_WRITE_TC:    tc_to_dscp = val[0];
      default:         ;
    endcase
  endtask

  // random packets until about target operations are queued, draining once midway
  task automatic run_random(int target);
    int queued;
    int n_prev;
    bit drained;
    queued  = 0;
    drained = 0;
    while (queued < target) begin
      if (!drained && queued >= target / 2) begin
        wait_idle();
        drained = 1;
      end
      if (pending_ops.size() < 12) begin
        n_prev = pending_ops.size();
        gen_packet();
        queued += pending_ops.size() - n_prev;
      end else begin
        @(posedge clk);
      end
    end
  endtask

  // reset, directed operations, then random phases under several settings
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty stack, unknown operation, overflow, read out of a full stack
    pending_ops.push_back(rand_op(OP_READ));
    pending_ops.push_back(rand_op(OP_CHECK));
    pending_ops.push_back(rand_op(OP_SWAP));
    pending_ops.push_back(rand_op(OP_POP));
    pending_ops.push_back(rand_op(OP_UNDEFINED));
    pending_ops.push_back(make_op(OP_START, '0, '0, '0, 8'd255, 6'd63, 1'b0));
    pending_ops.push_back(make_op(OP_PUSH, 20'hFFFFF, '0, '0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(OP_LOAD, LABEL_EXPLICIT_NULL, 3'd0, 8'd0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(OP_LOAD, 20'd5, 3'd7, 8'd255, '0, '0, 1'b0));
    pending_ops.push_back(make_op(OP_LOAD, 20'd16, 3'd3, 8'd2, '0, '0, 1'b0));
    pending_ops.push_back(rand_op(OP_PUSH));
    pending_ops.push_back(rand_op(OP_LOAD));
    pending_ops.push_back(rand_op(OP_READ));
    // ordinary check, reserved label, explicit null above the bottom
    pending_ops.push_back(rand_op(OP_CHECK));
    pending_ops.push_back(make_op(OP_POP, '0, '0, '0, '0, '0, 1'b1));
    pending_ops.push_back(rand_op(OP_CHECK));
    pending_ops.push_back(make_op(OP_POP, '0, '0, '0, '0, '0, 1'b0));
    pending_ops.push_back(rand_op(OP_CHECK));
    // swap then bottom pop over ipv4 copying the ttl back
    pending_ops.push_back(make_op(OP_SWAP, 20'd3, '0, '0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(OP_POP, '0, '0, '0, '0, '0, 1'b1));
    // ttl expiry and the ignored operation after it
    pending_ops.push_back(make_op(OP_START, '0, '0, '0, 8'd1, 6'h2A, 1'b0));
    pending_ops.push_back(make_op(OP_PUSH, 20'd100, '0, '0, '0, '0, 1'b0));
    pending_ops.push_back(rand_op(OP_SWAP));
    pending_ops.push_back(rand_op(OP_PUSH));
    // explicit null at the bottom of stack
    pending_ops.push_back(make_op(OP_START, '0, '0, '0, 8'd0, 6'd0, 1'b0));
    pending_ops.push_back(make_op(OP_LOAD, LABEL_EXPLICIT_NULL, 3'd5, 8'd77, '0, '0, 1'b0));
    pending_ops.push_back(rand_op(OP_CHECK));

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      if (ph == 2) begin
        sender_idle_pct = 49;
        sink_idle_pct   = 37;
      end else if (ph == 4) begin
        sender_idle_pct = 0;
        sink_idle_pct   = 0;
      end
      case (ph)
        0: begin
          write_reg(CFG_TTL_MODE, 8'd0);
          write_reg(CFG_DEFAULT_TTL, 8'd255);
          write_reg(CFG_WRITE_TC, 8'd1);
        end
        1: begin
          write_reg(CFG_TTL_MODE, 8'd1);
          write_reg(CFG_DEFAULT_TTL, 8'd0);
          write_reg(CFG_WRITE_TC, 8'd0);
        end
        2: begin
          write_reg(CFG_TTL_MODE, 8'd1);
          write_reg(CFG_DEFAULT_TTL, 8'd255);
          write_reg(CFG_WRITE_TC, 8'd1);
        end
        3: begin
          write_reg(CFG_TTL_MODE, 8'd0);
          write_reg(CFG_DEFAULT_TTL, 8'($urandom));
          write_reg(CFG_WRITE_TC, 8'd0);
        end
        4: begin
          write_reg(CFG_TTL_MODE, 8'd1);
          write_reg(CFG_DEFAULT_TTL, 8'($urandom));
          write_reg(CFG_WRITE_TC, 8'($urandom_range(1)));
        end
        default: begin
          write_reg(CFG_TTL_MODE, 8'd0);
          write_reg(CFG_DEFAULT_TTL, 8'd1);
          write_reg(CFG_WRITE_TC, 8'd1);
        end
      endcase
      @(posedge clk);
      cfg_we <= 1'b0;
      settings_used++;
      run_random(52);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, predicted_results.size());
      errors++;
    end
    $display("run: %0d operations (%0d taking effect), %0d result beats, %0d settings",
             ops_done, useful_ops, beats_seen, settings_used);
    $display("beats by status: ok %0d expired %0d null %0d reserved %0d",
             status_seen[ST_OK], status_seen[ST_TTL_EXPIRED], status_seen[ST_NULL_POPPED],
             status_seen[ST_RESERVED]);
    $display("  overflow %0d empty %0d ignored %0d",
             status_seen[ST_OVERFLOW], status_seen[ST_EMPTY], status_seen[ST_IGNORED]);
    if (errors == 0)
      $display("[mpls_label_stack_engine] OK");
    else
      $display("[mpls_label_stack_engine] ERROR");
    $finish;
  end

endmodule

/* files.f */
hdl/mlse_pkg.sv
hdl/mlse_state.sv
hdl/mlse_decode.sv
hdl/mlse_out.sv
hdl/mpls_label_stack_engine.sv
hdl/mlse_checker.sv
verif/tb_mpls_label_stack_engine.sv
